>>> src/cde_pkg.sv
// ============================================================================
// cde_pkg
// Shared types, codes and sizes for the circular deque engine.
// ============================================================================
package cde_pkg;

    // Ring store size and derived widths
    localparam int DEPTH       = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int IDXP_W      = IDX_W + 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int MAX_RESULTS = 64;
    localparam int LEFT_W      = $clog2(MAX_RESULTS + 1);

    // Field widths
    localparam int OP_W    = 3;
    localparam int VAL_W   = 32;
    localparam int LCNT_W  = 7;
    localparam int STAT_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_LIST_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_LIST_COUNT = 3'd5;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_LISTED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_REMOVED = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          opcode;
        logic signed [VAL_W-1:0]  value;
        logic [LCNT_W-1:0]        count;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value_res;
        logic [STAT_W-1:0]        status;
        logic                     last;
    } out_item_t;

    // What the output stage loads this cycle
    typedef enum logic [2:0] {
        EMIT_NONE    = 3'd0,
        EMIT_EMPTY   = 3'd1,
        EMIT_FULL    = 3'd2,
        EMIT_REMOVED = 3'd3,
        EMIT_LISTED  = 3'd4
    } emit_t;

    // Controller -> datapath
    typedef struct packed {
        logic   latch;       // capture the input transfer
        logic   push;        // write store, grow queue
        logic   pop;         // read removed entry, shrink queue
        logic   list_start;  // reset list walk, read front entry
        logic   list_next;   // step list walk, read next entry
        emit_t  emit;
    } cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             empty;
        logic             full;
        logic             list_zero;
        logic             list_last;
        logic             out_free;
        logic [CNT_W-1:0] count;
    } stat_t;

endpackage

>>> src/circular_deque_engine.sv
// ============================================================================
// circular_deque_engine
// Bounded double-ended queue of signed 32-bit values in a ring store.
// ============================================================================
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------
//  in       | input     | in_valid/in_ready  | in_item  : opcode, value, count
//  out      | output    | out_valid/out_ready| out_item : value_res, status, last
//
//  A push drops in_ready until it has been written; a pop steps through EXEC and
//  POP, a status result through EXEC and STATUS; a list emits one entry per cycle
//  while the output is free, off the single registered read port of the store.
//  Reset clears head and count; store contents stay undefined, no clear pass.
//  Output stalls hold the sequencer in its emit state; the output register
//  lets the next transfer come in while the last result still waits.
//
module circular_deque_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cde_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output cde_pkg::out_item_t  out_item
);

    cde_pkg::cmd_t  cmd;
    cde_pkg::stat_t stat;

    // Sequencer: decodes the captured opcode and steps the datapath
    cde_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, pointers, list walker, output register
    cde_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Queue never holds more than the store size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stat.count <= cde_pkg::CNT_W'(cde_pkg::DEPTH))
        else $error("entry count beyond store depth");

    // One transfer at a time: ready drops right after a transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

    // Results only loaded into a free output register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit != cde_pkg::EMIT_NONE |-> stat.out_free)
        else $error("result overwrote a pending transfer");

    // Status results carry a zero value and are marked last
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == cde_pkg::ST_EMPTY ||
                      out_item.status == cde_pkg::ST_FULL)
        |-> out_item.value_res == '0 && out_item.last)
        else $error("status result with nonzero value or not last");

endmodule

>>> src/cde_ctrl.sv
// ============================================================================
// cde_ctrl
// Sequencer: takes one transfer, runs it, hands results to the output stage.
// ============================================================================
module cde_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  cde_pkg::stat_t stat,
    output cde_pkg::cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_EXEC   = 5'b00010,
        S_STATUS = 5'b00100,
        S_POP    = 5'b01000,
        S_LIST   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic is_push;
    logic is_pop;
    logic is_list;

    assign is_push = (stat.op == cde_pkg::OP_PUSH_FRONT) || (stat.op == cde_pkg::OP_PUSH_BACK);
    assign is_pop  = (stat.op == cde_pkg::OP_POP_FRONT)  || (stat.op == cde_pkg::OP_POP_BACK);
    assign is_list = (stat.op == cde_pkg::OP_LIST_ALL)   || (stat.op == cde_pkg::OP_LIST_COUNT);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = cde_pkg::EMIT_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                priority if (is_push)
                begin
                    if (stat.full)
                        state_next = S_STATUS;
                    else
                    begin
                        cmd.push   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (is_pop || is_list)
                begin
                    if (stat.empty)
                        state_next = S_STATUS;
                    else if (is_pop)
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_POP;
                    end
                    else if (stat.list_zero)
                        state_next = S_IDLE;
                    else
                    begin
                        cmd.list_start = 1'b1;
                        state_next     = S_LIST;
                    end
                end
                else
                    state_next = S_IDLE;  // unused opcode
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = is_push ? cde_pkg::EMIT_FULL : cde_pkg::EMIT_EMPTY;
                    state_next = S_IDLE;
                end
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = cde_pkg::EMIT_REMOVED;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = cde_pkg::EMIT_LISTED;
                    if (stat.list_last)
                        state_next = S_IDLE;
                    else
                        cmd.list_next = 1'b1;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> src/cde_datapath.sv
// ============================================================================
// cde_datapath
// Ring store, head/count pointers, list walker and output register.
// ============================================================================
module cde_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  cde_pkg::in_item_t   in_item,
    input  cde_pkg::cmd_t       cmd,
    output cde_pkg::stat_t      stat,
    output logic                out_valid,
    input  logic                out_ready,
    output cde_pkg::out_item_t  out_item
);

    localparam int IDX_W  = cde_pkg::IDX_W;
    localparam int IDXP_W = cde_pkg::IDXP_W;
    localparam int CNT_W  = cde_pkg::CNT_W;
    localparam int LEFT_W = cde_pkg::LEFT_W;

    // Captured transfer
    logic [cde_pkg::OP_W-1:0]         op_reg;
    logic signed [cde_pkg::VAL_W-1:0] val_reg;
    logic [cde_pkg::LCNT_W-1:0]       lcnt_reg;

    // Queue pointers
    logic [IDX_W-1:0]  head_reg,  head_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    // List walker
    logic [IDX_W-1:0]  off_reg,  off_next;
    logic [LEFT_W-1:0] left_reg, left_next;

    // Store
    logic [cde_pkg::VAL_W-1:0] mem [cde_pkg::DEPTH];
    logic [cde_pkg::VAL_W-1:0] rd_data_reg;
    logic                      rd_en;
    logic                      we;
    logic [IDX_W-1:0]          raddr;
    logic [IDX_W-1:0]          waddr;

    // Output register
    logic                out_valid_reg, out_valid_next;
    cde_pkg::out_item_t  out_reg,       out_next;

    logic              front;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  head_dec;
    logic [IDXP_W-1:0] off_p1;
    logic [IDX_W-1:0]  off_adv;
    logic [LEFT_W-1:0] list_n;

    // head + offset, wrapped once
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                                 input logic [IDX_W-1:0] o);
        logic [IDXP_W-1:0] sum;
        sum = {1'b0, h} + {1'b0, o};
        if (sum >= IDXP_W'(cde_pkg::DEPTH))
            sum = sum - IDXP_W'(cde_pkg::DEPTH);
        return sum[IDX_W-1:0];
    endfunction

    assign front    = (op_reg == cde_pkg::OP_PUSH_FRONT) || (op_reg == cde_pkg::OP_POP_FRONT);
    assign head_inc = (head_reg == IDX_W'(cde_pkg::DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_W'(cde_pkg::DEPTH - 1) : head_reg - 1'b1;

    // Listing wraps back to the front after the back entry
    assign off_p1  = {1'b0, off_reg} + 1'b1;
    assign off_adv = (off_p1 == IDXP_W'(count_reg)) ? '0 : off_p1[IDX_W-1:0];

    always_comb
    begin
        if (op_reg == cde_pkg::OP_LIST_ALL)
            list_n = LEFT_W'(count_reg);
        else if (lcnt_reg > cde_pkg::LCNT_W'(cde_pkg::MAX_RESULTS))
            list_n = LEFT_W'(cde_pkg::MAX_RESULTS);
        else
            list_n = LEFT_W'(lcnt_reg);
    end

    // Pointer and walker updates
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        off_next   = off_reg;
        left_next  = left_reg;
        we         = cmd.push;
        rd_en      = cmd.pop || cmd.list_start || cmd.list_next;
        waddr      = front ? head_dec : slot_of(head_reg, count_reg[IDX_W-1:0]);
        raddr      = head_reg;
        if (cmd.push)
        begin
            head_next  = front ? head_dec : head_reg;
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            raddr      = front ? head_reg
                               : slot_of(head_reg, IDX_W'(count_reg - 1'b1));
            head_next  = front ? head_inc : head_reg;
            count_next = count_reg - 1'b1;
        end
        if (cmd.list_start)
        begin
            raddr     = head_reg;
            off_next  = '0;
            left_next = list_n;
        end
        if (cmd.list_next)
        begin
            raddr     = slot_of(head_reg, off_adv);
            off_next  = off_adv;
            left_next = left_reg - 1'b1;
        end
    end

    // Output stage
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;
        unique case (cmd.emit)
            cde_pkg::EMIT_NONE:
            begin
            end
            cde_pkg::EMIT_EMPTY:
            begin
                out_valid_next     = 1'b1;
                out_next.value_res = '0;
                out_next.status    = cde_pkg::ST_EMPTY;
                out_next.last      = 1'b1;
            end
            cde_pkg::EMIT_FULL:
            begin
                out_valid_next     = 1'b1;
                out_next.value_res = '0;
                out_next.status    = cde_pkg::ST_FULL;
                out_next.last      = 1'b1;
            end
            cde_pkg::EMIT_REMOVED:
            begin
                out_valid_next     = 1'b1;
                out_next.value_res = rd_data_reg;
                out_next.status    = cde_pkg::ST_REMOVED;
                out_next.last      = 1'b1;
            end
            cde_pkg::EMIT_LISTED:
            begin
                out_valid_next     = 1'b1;
                out_next.value_res = rd_data_reg;
                out_next.status    = cde_pkg::ST_LISTED;
                out_next.last      = (left_reg == LEFT_W'(1));
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= in_item.opcode;
            val_reg  <= in_item.value;
            lcnt_reg <= in_item.count;
        end
        off_reg  <= off_next;
        left_reg <= left_next;
        out_reg  <= out_next;
    end

    // Ring store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= val_reg;
        if (rd_en)
            rd_data_reg <= mem[raddr];
    end

    assign stat.op        = op_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CNT_W'(cde_pkg::DEPTH));
    assign stat.list_zero = (list_n == '0);
    assign stat.list_last = (left_reg == LEFT_W'(1));
    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.count     = count_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
